>>> src/jkv_pkg.sv
// shared types, constants and codes for the json key/value extractor
package jkv_pkg;

   localparam int KEY_BYTES  = 8;
   localparam int KEY_IDX_W  = 3;
   localparam int POS_BITS   = 4;
   localparam int DEPTH_BITS = 16;
   localparam int CLS_BITS   = 4;
   localparam int CHAR_BITS  = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = KEY_BYTES * CHAR_BITS;

   typedef enum logic [CLS_BITS-1:0] {
      CLS_START_OBJECT = 4'd0,
      CLS_IN_OBJECT    = 4'd1,
      CLS_AFTER_VALUE  = 4'd2,
      CLS_IN_STRING    = 4'd3,
      CLS_END_KEY      = 4'd4,
      CLS_KEY_COLON    = 4'd5,
      CLS_START_ARRAY  = 4'd6,
      CLS_AFTER_ARRAY  = 4'd7,
      CLS_AFTER_OBJECT = 4'd8,
      CLS_DONE         = 4'd9,
      CLS_OTHER        = 4'd15
   } cls_type;

   typedef enum logic [2:0] {
      MODE_WAIT  = 3'b001,
      MODE_MATCH = 3'b010,
      MODE_PASS  = 3'b100
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CHARS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 1'b1;

   typedef struct packed {
      mode_type                mode;
      logic [POS_BITS-1:0]     key_pos;
      logic [CLS_BITS-1:0]     prev_class;
      logic [DEPTH_BITS-1:0]   depth;
      logic                    found;
   } ctx_type;

   typedef struct packed {
      logic                    value_valid;
      logic [CLS_BITS-1:0]     value_class;
      logic [CHAR_BITS-1:0]    value_char;
      logic                    not_found;
   } result_type;

endpackage

>>> src/jkv_ifaces.sv
// token and result channel interfaces
interface jkv_req_if import jkv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CLS_BITS-1:0]  token_class;
   logic [CHAR_BITS-1:0] token_char;

   modport source (output valid, output token_class, output token_char, input ready);
   modport sink   (input valid, input token_class, input token_char, output ready);
endinterface

interface jkv_rsp_if import jkv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 value_valid;
   logic [CLS_BITS-1:0]  value_class;
   logic [CHAR_BITS-1:0] value_char;
   logic                 not_found;

   modport source (output valid, output value_valid, output value_class,
                   output value_char, output not_found, input ready);
   modport sink   (input valid, input value_valid, input value_class,
                   input value_char, input not_found, output ready);
endinterface

>>> src/jkv_step.sv
// per-token context update: depth tracking, key compare and value pass-through
module jkv_step import jkv_pkg::*; (
   input  ctx_type                           ctx,
   input  logic [CLS_BITS-1:0]               cls,
   input  logic [CHAR_BITS-1:0]              ch,
   input  logic [KEY_BYTES-1:0][CHAR_BITS-1:0] key_chars,
   input  logic [POS_BITS-1:0]               key_length,
   output ctx_type                           ctx_next,
   output result_type                        res
);

   logic [DEPTH_BITS-1:0] depth;
   logic [POS_BITS-1:0]   klen;
   logic                  exhausted;
   logic                  mismatch;
   logic                  expect_key;
   logic                  ended;
   logic                  obj_end;

   always_comb begin
      depth = ctx.depth;
      if ((cls == CLS_START_OBJECT || cls == CLS_START_ARRAY) && depth != '1) begin
         depth = depth + 1'b1;
      end
      if ((cls == CLS_AFTER_OBJECT || cls == CLS_AFTER_ARRAY || cls == CLS_DONE) &&
          depth != '0) begin
         depth = depth - 1'b1;
      end
   end

   assign klen      = (key_length > POS_BITS'(KEY_BYTES)) ? POS_BITS'(KEY_BYTES) : key_length;
   assign exhausted = ctx.key_pos >= klen;
   assign mismatch  = key_chars[ctx.key_pos[KEY_IDX_W-1:0]] != ch;
   assign expect_key = ctx.prev_class inside {CLS_START_OBJECT, CLS_IN_OBJECT,
                                              CLS_AFTER_VALUE};
   assign ended = (depth <= DEPTH_BITS'(1)) &&
                  (cls inside {CLS_IN_OBJECT, CLS_AFTER_ARRAY, CLS_AFTER_OBJECT});
   assign obj_end = (depth == '0) && (cls == CLS_AFTER_OBJECT || cls == CLS_DONE);

   always_comb begin
      ctx_next            = ctx;
      ctx_next.depth      = depth;
      ctx_next.prev_class = cls;
      res                 = '0;
      case (ctx.mode)
         MODE_MATCH: begin
            if (exhausted && cls == CLS_END_KEY) begin
               ctx_next.mode  = MODE_PASS;
               ctx_next.found = 1'b1;
            end else if (exhausted || cls == CLS_KEY_COLON || mismatch) begin
               ctx_next.mode = MODE_WAIT;
            end else begin
               ctx_next.key_pos = ctx.key_pos + 1'b1;
            end
         end
         MODE_PASS: begin
            if (cls != CLS_KEY_COLON) begin
               if (ended || cls == CLS_DONE) begin
                  ctx_next.mode = MODE_WAIT;
               end
               res.value_valid = 1'b1;
               res.value_class = cls;
               res.value_char  = ch;
            end
         end
         default: begin
            ctx_next.mode = MODE_WAIT;
            if (depth == DEPTH_BITS'(1) && expect_key && cls == CLS_IN_STRING) begin
               ctx_next.key_pos = '0;
               ctx_next.mode    = MODE_MATCH;
            end
         end
      endcase
      if (obj_end) begin
         res.not_found  = !ctx_next.found;
         ctx_next.found = 1'b0;
      end
   end

endmodule

>>> src/json_key_value_extractor.sv
// top level: token input register, context update and result register
// an accepted token passes through the token register and then the result register, one result per token
// throughput: one token per cycle while the result register is not stalled; the context register closes a loop
// a stalled result register backs up into the token register, then req ready drops
// reset (synchronous, active high) clears the context, key registers and valid flags
module json_key_value_extractor import jkv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   jkv_req_if.sink               req_chan,
   jkv_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                               tok_vld_ff, tok_vld_in;
   logic [CLS_BITS-1:0]                tok_cls_ff;
   logic [CHAR_BITS-1:0]               tok_char_ff;
   logic                               rsp_vld_ff, rsp_vld_in;
   result_type                         rsp_ff;
   ctx_type                            ctx_ff;
   ctx_type                            ctx_in;
   result_type                         res;
   logic [KEY_BYTES-1:0][CHAR_BITS-1:0] key_chars_ff;
   logic [POS_BITS-1:0]                key_length_ff;
   logic                               adv;
   logic                               req_fire;

   assign adv      = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = !tok_vld_ff || adv;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign tok_vld_in = req_fire || (tok_vld_ff && !adv);
   assign rsp_vld_in = (tok_vld_ff && adv) || (rsp_vld_ff && !rsp_chan.ready);

   jkv_step u_step (
      .ctx        (ctx_ff),
      .cls        (tok_cls_ff),
      .ch         (tok_char_ff),
      .key_chars  (key_chars_ff),
      .key_length (key_length_ff),
      .ctx_next   (ctx_in),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_vld_ff          <= 1'b0;
         rsp_vld_ff          <= 1'b0;
         ctx_ff.mode         <= MODE_WAIT;
         ctx_ff.key_pos      <= '0;
         ctx_ff.prev_class   <= CLS_OTHER;
         ctx_ff.depth        <= '0;
         ctx_ff.found        <= 1'b0;
         key_chars_ff        <= '0;
         key_length_ff       <= '0;
      end else begin
         tok_vld_ff <= tok_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (tok_vld_ff && adv) begin
            ctx_ff <= ctx_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_CHARS:  key_chars_ff  <= csr_wdata;
               CSR_KEY_LENGTH: key_length_ff <= csr_wdata[POS_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tok_cls_ff  <= req_chan.token_class;
         tok_char_ff <= req_chan.token_char;
      end
      if (tok_vld_ff && adv) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.value_valid = rsp_ff.value_valid;
   assign rsp_chan.value_class = rsp_ff.value_class;
   assign rsp_chan.value_char  = rsp_ff.value_char;
   assign rsp_chan.not_found   = rsp_ff.not_found;

endmodule

>>> src/jkv_checker.sv
// port-level checks for the json key/value extractor and their bind
module jkv_checker import jkv_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 value_valid,
   input logic [CLS_BITS-1:0]  value_class,
   input logic [CHAR_BITS-1:0] value_char
);

   // held result stays presented
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // outside a value the pass-through fields are zero
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !value_valid |-> value_class == '0 && value_char == '0)
      else $error("pass-through fields set outside a value");

   // key colon tokens are never passed on
   a_no_colon_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && value_valid |-> value_class != CLS_KEY_COLON)
      else $error("key colon token passed through");

   // an item accepted while no result is held shows a result after the token and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("result missing after accepted item");

   // no result straight out of reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind json_key_value_extractor jkv_checker u_jkv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .value_valid (rsp_chan.value_valid),
   .value_class (rsp_chan.value_class),
   .value_char  (rsp_chan.value_char)
);
